FILE: rtl/core/wang_tile_grid_generator_unit_defines.svh
// assertion macros shared by the wang tile grid generator rtl
`ifndef WANG_TILE_GRID_GENERATOR_UNIT_DEFINES_SVH
`define WANG_TILE_GRID_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define WTG_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("wtg assertion failed");
// concurrent check on the block clock and reset
`define WTG_ASSERT(lbl, prop) \
  `WTG_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define WTG_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop)
`define WTG_ASSERT(lbl, prop)
`endif

`endif

FILE: rtl/core/wtg_pkg.sv
// shared types, constants and tile selection for the wang tile grid generator
`timescale 1ns / 1ps

package wtg_pkg;

  localparam int MAX_GRID_WIDTH  = 1024;
  localparam int MAX_GRID_HEIGHT = 1024;

  // field widths
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int SIZE_W = 11;
  localparam int RND_W  = 4;
  localparam int CODE_W = 4;

  // tile code bit positions
  localparam int RIGHT_POS  = 0;
  localparam int TOP_POS    = 1;
  localparam int LEFT_POS   = 2;
  localparam int BOTTOM_POS = 3;

  localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_GRID_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_GRID_HEIGHT);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  // line store access for one cycle
  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic             wr_bit;
  } line_req_t;

  // clamp a size register to 1..max
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > max_v) begin
      res = max_v;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // deposit random bits, lowest first, into the unconstrained edge positions
  function automatic logic [CODE_W-1:0] pick_tile(input logic [RND_W-1:0] rnd,
                                                  input logic left_bit,
                                                  input logic top_bit,
                                                  input logic has_left,
                                                  input logic has_top);
    logic [CODE_W-1:0] code;
    code = rnd;
    if (has_left && has_top) begin
      code[RIGHT_POS]  = rnd[0];
      code[TOP_POS]    = top_bit;
      code[LEFT_POS]   = left_bit;
      code[BOTTOM_POS] = rnd[1];
    end else if (has_left) begin
      code[RIGHT_POS]  = rnd[0];
      code[TOP_POS]    = rnd[1];
      code[LEFT_POS]   = left_bit;
      code[BOTTOM_POS] = rnd[2];
    end else if (has_top) begin
      code[RIGHT_POS]  = rnd[0];
      code[TOP_POS]    = top_bit;
      code[LEFT_POS]   = rnd[1];
      code[BOTTOM_POS] = rnd[2];
    end
    return code;
  endfunction

endpackage

FILE: rtl/core/wtg_line_mem.sv
// one-bit line store holding the bottom edges of the previous tile row
`timescale 1ns / 1ps

module wtg_line_mem
  import wtg_pkg::*;
(
  input  logic      clk,
  input  line_req_t req,
  output logic      rd_bit
);

  logic mem [MAX_GRID_WIDTH];
  logic rd_bit_r;

  // synchronous read, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_bit_r <= mem[req.rd_addr];
    end
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_bit;
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

FILE: rtl/core/wang_tile_grid_generator_unit.sv
// Wang tile grid generator: one random two-color tile per item in raster order.
// Throughput is one tile per clock unless the output stalls; items pass through
// the first stage to the output register. On acceptance the bottom edge of the
// tile above is read from a 1-bit single-read, single-write line store; the
// first stage picks the tile from that bit and the previous tile's right edge
// and writes the new bottom edge back as it advances. When the row is one tile
// wide the write of one tile meets the read of the next at the same entry, and
// the written bit is forwarded. The line store needs no clearing after reset:
// row 0 ignores the bit it reads. grid_width and grid_height are clamped to
// 1..1024 and may only be changed while the block is idle.
`timescale 1ns / 1ps
`include "wang_tile_grid_generator_unit_defines.svh"

module wang_tile_grid_generator_unit
  import wtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] random_bits
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] tile_code, [13:4] column, [23:14] row
  output logic        out_tlast   // grid_done
);

  typedef struct packed {
    logic [RND_W-1:0] rnd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
    logic             has_left;
    logic             has_top;
    logic             fwd;
    logic             fwd_bit;
  } s1_t;

  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic              left_r, left_nxt;
  logic              s1_v_r, s1_v_nxt;
  s1_t               s1_r, s1_nxt;
  logic              out_v_r, out_v_nxt;
  logic [23:0]       out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc, s1_adv;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              last_col, last_row;
  logic              rd_bit, top_bit;
  logic [CODE_W-1:0] code;
  line_req_t         line_req;

  // handshake
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  width_nxt  = cfg_wdata;
        CFG_GRID_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // raster position counters
  assign width_eff  = clamp_size(width_r, MAX_W_SIZE);
  assign height_eff = clamp_size(height_r, MAX_H_SIZE);
  assign col_inc    = SIZE_W'(col_cnt_r) + SIZE_W'(1);
  assign row_inc    = SIZE_W'(row_cnt_r) + SIZE_W'(1);
  assign last_col   = col_inc >= width_eff;
  assign last_row   = row_inc >= height_eff;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_cnt_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // tile selection in the first stage
  assign top_bit = s1_r.fwd ? s1_r.fwd_bit : rd_bit;
  assign code    = pick_tile(s1_r.rnd, left_r, top_bit, s1_r.has_left, s1_r.has_top);

  // line store access
  always_comb begin
    line_req.rd_en   = in_acc;
    line_req.rd_addr = col_cnt_r;
    line_req.wr_en   = s1_adv;
    line_req.wr_addr = s1_r.col;
    line_req.wr_bit  = code[BOTTOM_POS];
  end

  wtg_line_mem u_line_mem (
    .clk    (clk),
    .req    (line_req),
    .rd_bit (rd_bit)
  );

  // first stage: position and read issue, forward a same-entry write
  always_comb begin
    s1_nxt   = s1_r;
    s1_v_nxt = s1_v_r;
    if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_v_nxt        = 1'b1;
      s1_nxt.rnd      = in_tdata[RND_W-1:0];
      s1_nxt.col      = col_cnt_r;
      s1_nxt.row      = row_cnt_r;
      s1_nxt.done     = last_col && last_row;
      s1_nxt.has_left = col_cnt_r != '0;
      s1_nxt.has_top  = row_cnt_r != '0;
      s1_nxt.fwd      = s1_adv && (s1_r.col == col_cnt_r);
      s1_nxt.fwd_bit  = code[BOTTOM_POS];
    end
  end

  // right edge carried to the next tile
  assign left_nxt = s1_adv ? code[RIGHT_POS] : left_r;

  // output register
  always_comb begin
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = {s1_r.row, s1_r.col, code};
      out_last_nxt = s1_r.done;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SIZE_W'(13);
      height_r  <= SIZE_W'(10);
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      left_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      left_r    <= left_nxt;
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a stalled first stage blocks new items
  `WTG_ASSERT(a_stall_blocks_input, (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
  // a write meeting the read of the same entry is forwarded
  `WTG_ASSERT(a_same_entry_forward,
    (in_acc && s1_adv && (s1_r.col == col_cnt_r)) |=> (s1_v_r && s1_r.fwd))
  // the last tile of a row restarts the column count
  `WTG_ASSERT(a_row_wrap, (in_acc && last_col) |=> (col_cnt_r == '0))
  // a new item in the first stage sees no left neighbor only in column zero
  `WTG_ASSERT(a_left_flag, s1_v_r |-> (s1_r.has_left == (s1_r.col != '0)))

endmodule
